@@ hw/rtl/dsl_lex_pkg.sv @@
// shared types, constants and keyword helpers for the keyword lexer
// no dependencies; imported by dsl_lex_core, dsl_lex_fifo and dsl_keyword_lexer_top
package dsl_lex_pkg;

   localparam int LINE_BITS  = 24;
   localparam int INDEX_BITS = 16;

   // token codes on the result channel
   typedef enum logic [3:0] {
      TOK_POINT      = 4'd0,
      TOK_LINE       = 4'd1,
      TOK_CIRCLE     = 4'd2,
      TOK_CONSTRAINT = 4'd3,
      TOK_IDENT      = 4'd4,
      TOK_ASSIGN     = 4'd5,
      TOK_LPAREN     = 4'd6,
      TOK_RPAREN     = 4'd7,
      TOK_COMMA      = 4'd8,
      TOK_SEMI       = 4'd9
   } token_kind_type;

   // source characters with a meaning of their own
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_SEMI   = ";";

   // keywords, left aligned and padded to ten characters
   localparam int KW_COUNT = 4;
   localparam int KW_CHARS = 10;
   localparam logic [0:KW_COUNT-1][8*KW_CHARS-1:0] KW_TEXT = '{
      "point     ", "line      ", "circle    ", "constraint"
   };
   localparam logic [0:KW_COUNT-1][3:0] KW_LEN = '{4'd5, 4'd4, 4'd6, 4'd10};

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [3:0]            token_type;
      logic [LINE_BITS-1:0]  line_number;
      logic [INDEX_BITS-1:0] token_index;
      logic                  run_last;
   } rsp_type;

   // up to two tokens produced by one byte; push1 only together with push0
   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type tok0;
      rsp_type tok1;
   } lex_push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9");
   endfunction

   // keywords that still match after character c lands at position pos
   function automatic logic [KW_COUNT-1:0] kw_char_match(input logic [3:0] pos,
                                                         input logic [7:0] c);
      logic [KW_COUNT-1:0] m;
      logic [3:0]          p;
      m = '0;
      p = (pos > 4'(KW_CHARS - 1)) ? 4'(KW_CHARS - 1) : pos;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos < KW_LEN[k]) begin
            m[k] = (KW_TEXT[k][8*(KW_CHARS-1-int'(p)) +: 8] == c);
         end
      end
      return m;
   endfunction

   // token code of a finished identifier
   function automatic logic [3:0] kw_type(input logic [3:0] len,
                                          input logic [KW_COUNT-1:0] alive);
      logic [3:0] t;
      t = TOK_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive[k] && len == KW_LEN[k]) begin
            t = 4'(k);
         end
      end
      return t;
   endfunction

endpackage

@@ hw/rtl/dsl_lex_core.sv @@
// scanner state and per-byte token decision for the keyword lexer
// depends on dsl_lex_pkg
module dsl_lex_core
   import dsl_lex_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_take,
   input  req_type      in_data,
   output lex_push_type push
);

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_IDENT   = 2'd1,
      MODE_COMMENT = 2'd2
   } scan_mode_type;

   localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   scan_mode_type           mode_ff,   mode_in;
   logic                    slash_ff,  slash_in;
   logic [LINE_BITS-1:0]    line_ff,   line_in;
   logic [3:0]              len_ff,    len_in;
   logic [KW_COUNT-1:0]     alive_ff,  alive_in;
   logic [INDEX_BITS-1:0]   count_ff,  count_in;

   // per-byte decision
   always_comb begin
      logic [7:0]            c;
      logic                  handled;
      logic                  e_flush;
      logic                  e_punct;
      logic                  e_final;
      logic [3:0]            flush_type;
      logic [3:0]            punct_type;
      logic [INDEX_BITS-1:0] idx1;
      logic [INDEX_BITS-1:0] idx2;

      c          = in_data.char_byte;
      handled    = 1'b0;
      e_flush    = 1'b0;
      e_punct    = 1'b0;
      e_final    = 1'b0;
      flush_type = kw_type(len_ff, alive_ff);
      punct_type = TOK_ASSIGN;
      mode_in    = mode_ff;
      slash_in   = slash_ff;
      line_in    = line_ff;
      len_in     = len_ff;
      alive_in   = alive_ff;

      // comment body, or the byte after a lone slash
      if (mode_ff == MODE_COMMENT) begin
         if (c == CH_LF) begin
            if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
            mode_in = MODE_NORMAL;
         end
         handled = 1'b1;
      end else if (slash_ff) begin
         slash_in = 1'b0;
         if (c == CH_SLASH) begin
            mode_in = MODE_COMMENT;
            handled = 1'b1;
         end
      end

      // continue or end an open identifier
      if (!handled && mode_in == MODE_IDENT) begin
         if (is_word_char(c)) begin
            alive_in = alive_ff & kw_char_match(len_ff, c);
            if (len_ff != 4'hF) len_in = len_ff + 1'b1;
            handled  = 1'b1;
         end else begin
            e_flush  = 1'b1;
            mode_in  = MODE_NORMAL;
            len_in   = '0;
            alive_in = '1;
         end
      end

      // plain byte
      if (!handled) begin
         mode_in = MODE_NORMAL;
         if (c == CH_LF) begin
            if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
         end else if (c == CH_HASH) begin
            mode_in = MODE_COMMENT;
         end else if (c == CH_SLASH) begin
            slash_in = 1'b1;
         end else if (is_letter(c)) begin
            mode_in  = MODE_IDENT;
            alive_in = kw_char_match(4'd0, c);
            len_in   = 4'd1;
         end else if (c == CH_EQUAL) begin
            e_punct    = 1'b1;
            punct_type = TOK_ASSIGN;
         end else if (c == CH_LPAREN) begin
            e_punct    = 1'b1;
            punct_type = TOK_LPAREN;
         end else if (c == CH_RPAREN) begin
            e_punct    = 1'b1;
            punct_type = TOK_RPAREN;
         end else if (c == CH_COMMA) begin
            e_punct    = 1'b1;
            punct_type = TOK_COMMA;
         end else if (c == CH_SEMI) begin
            e_punct    = 1'b1;
            punct_type = TOK_SEMI;
         end
      end

      // last byte flushes an open identifier; it keeps its current length
      if (in_data.is_final && mode_in == MODE_IDENT) begin
         e_final    = 1'b1;
         flush_type = kw_type(len_in, alive_in);
      end

      // token indices, saturating
      idx1 = (count_ff != INDEX_MAX) ? count_ff + 1'b1 : count_ff;
      idx2 = (idx1 != INDEX_MAX) ? idx1 + 1'b1 : idx1;

      push.push0 = in_take && (e_flush || e_punct || e_final);
      push.push1 = in_take && e_flush && e_punct;

      push.tok0.token_type  = (e_flush || e_final) ? flush_type : punct_type;
      push.tok0.line_number = line_ff;
      push.tok0.token_index = count_ff;
      push.tok0.run_last    = !(e_flush && e_punct);

      push.tok1.token_type  = punct_type;
      push.tok1.line_number = line_ff;
      push.tok1.token_index = idx1;
      push.tok1.run_last    = 1'b1;

      if (e_flush && e_punct) begin
         count_in = idx2;
      end else if (e_flush || e_punct || e_final) begin
         count_in = idx1;
      end else begin
         count_in = count_ff;
      end

      // end of source text returns everything to its start values
      if (in_data.is_final) begin
         mode_in  = MODE_NORMAL;
         slash_in = 1'b0;
         line_in  = LINE_BITS'(1);
         len_in   = '0;
         alive_in = '1;
         count_in = '0;
      end
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         slash_ff <= 1'b0;
         line_ff  <= LINE_BITS'(1);
         len_ff   <= '0;
         alive_ff <= '1;
         count_ff <= '0;
      end else if (in_take) begin
         mode_ff  <= mode_in;
         slash_ff <= slash_in;
         line_ff  <= line_in;
         len_ff   <= len_in;
         alive_ff <= alive_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hw/rtl/dsl_lex_fifo.sv @@
// four-entry result queue; takes up to two tokens per cycle, gives one
// depends on dsl_lex_pkg
module dsl_lex_fifo
   import dsl_lex_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lex_push_type push,
   output logic         room2,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_type      out_data
);

   rsp_type    mem_ff [4];
   logic [1:0] wr_ff,  wr_in;
   logic [1:0] rd_ff,  rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [2:0] npush;

   // pointer and fill bookkeeping
   always_comb begin
      pop    = out_valid && out_ready;
      npush  = 3'(push.push0) + 3'(push.push1);
      wr_in  = wr_ff + npush[1:0];
      rd_in  = rd_ff + 2'(pop);
      cnt_in = cnt_ff + npush - 3'(pop);
   end

   assign room2     = (cnt_ff <= 3'd2);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_data  = mem_ff[rd_ff];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.push0) mem_ff[wr_ff] <= push.tok0;
      if (push.push1) mem_ff[wr_ff + 2'd1] <= push.tok1;
   end

endmodule

@@ hw/rtl/dsl_keyword_lexer_top.sv @@
// top level of the keyword lexer: byte in, tokens out
// depends on dsl_lex_pkg, dsl_lex_core, dsl_lex_fifo
//
//   channel   ports                          payload
//   request   req_valid / req_ready          req_data  (req_type: byte, last flag)
//   response  rsp_valid / rsp_ready          rsp_data  (rsp_type: token)
//
// one byte is taken per cycle while req_ready is high; its tokens (zero, one
// or two) are written to a four-entry result queue in the same edge.
// a byte ending an identifier with punctuation yields two tokens, so the pace
// is set by the single-token-per-cycle read port of the result queue.
// req_ready is high while the queue has room for two tokens; it does not
// depend on rsp_ready in the same cycle. reset clears the scanner and queue.
module dsl_keyword_lexer_top
   import dsl_lex_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   lex_push_type push;
   logic         room2;
   logic         take;

   // request transfer
   assign req_ready = room2;
   assign take      = req_valid && room2;

   dsl_lex_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_take (take),
      .in_data (req_data),
      .push    (push)
   );

   dsl_lex_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
